>>> rtl/llf_pkg.sv
// Ladder lowpass filter: shared widths, payload types, datapath codes, microcode ROM.
package llf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 24;
  localparam int FRAC_SA  = SAMPLE_W - 1;
  localparam int FRAC_ST  = STATE_W - 4;
  localparam int ALIGN_SH = FRAC_ST - FRAC_SA;
  localparam int PEAK_W   = SAMPLE_W + 1;

  localparam int CFG_W    = 16;
  localparam int QN_W     = CFG_W + 1;
  localparam int COEF_W   = 20;
  localparam int TMP_W    = 37;
  localparam int MUL_A_W  = TMP_W;
  localparam int MUL_B_W  = (STATE_W > 19) ? STATE_W + 1 : 21;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int RAW_W    = PROD_W + 2;
  localparam int STEP_W   = 6;

  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CFG_W-1:0] CUTOFF_RST = 16'd52429;
  localparam logic [CFG_W-1:0] RESO_RST   = 16'd0;

  localparam logic REG_CUTOFF    = 1'b0;
  localparam logic REG_RESONANCE = 1'b1;

  localparam int K_EIGHT_TENTHS = 52429;
  localparam int K_FIVE_SIX     = 367002;
  localparam int K_SIXTH        = 10923;
  localparam int ONE_Q16        = 65536;

  localparam logic [STEP_W-1:0] ADDR_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] ADDR_COEF = STEP_W'(1);
  localparam logic [STEP_W-1:0] ADDR_FILT = STEP_W'(10);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [PEAK_W-1:0]   peak_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [TMP_W-1:0]    tmp_t;
  typedef logic signed [MUL_A_W-1:0]  mul_a_t;
  typedef logic signed [MUL_B_W-1:0]  mul_b_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [RAW_W-1:0]    raw_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       start_of_run;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [SAMPLE_W-1:0]        peak_level;
  } out_item_t;

  // multiplier operand A
  typedef enum logic [3:0] {
    A_CUT, A_QN, A_T0, A_T1, A_KQ, A_ST1, A_ST2, A_ST3, A_ST4
  } a_sel_e;

  // multiplier operand B
  typedef enum logic [3:0] {
    B_QN, B_K56, B_K08, B_K6, B_PC, B_FB, B_RES, B_ST4, B_T0
  } b_sel_e;

  typedef enum logic [2:0] {
    BS_ZERO, BS_ACC, BS_CUT, BS_ONE, BS_XIN, BS_T0
  } base_e;

  typedef enum logic [2:0] {
    XS_ZERO, XS_PROD, XS_PRIOR, XS_T0, XS_ST1, XS_ST2, XS_ST3
  } xsrc_e;

  typedef enum logic [2:0] {
    SH_0, SH_16, SH_17, SH_FRAC, SH_32
  } xsh_e;

  typedef enum logic [3:0] {
    D_NONE, D_ACC, D_T0, D_T1, D_PC, D_KQ, D_PRIOR, D_ST1, D_ST2, D_ST3, D_ST4
  } dest_e;

  typedef enum logic [1:0] {
    FL_NEXT, FL_DISPATCH, FL_RETURN, FL_EMIT
  } flow_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    base_e  base;
    xsrc_e  xsrc;
    xsh_e   xsh;
    logic   neg;
    logic   rsh;
    logic   sat;
    dest_e  dest;
    flow_e  flow;
  } ucode_t;

  function automatic ucode_t uw(a_sel_e a, b_sel_e b, base_e bs, xsrc_e xs, xsh_e sh,
                                logic ng, logic rs, logic st, dest_e d, flow_e f);
    ucode_t w;
    w.a_sel = a;
    w.b_sel = b;
    w.base  = bs;
    w.xsrc  = xs;
    w.xsh   = sh;
    w.neg   = ng;
    w.rsh   = rs;
    w.sat   = st;
    w.dest  = d;
    w.flow  = f;
    return w;
  endfunction

  // ALU of each step consumes the product registered by the step before it.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    w = uw(A_CUT, B_QN, BS_ZERO, XS_ZERO, SH_0, 1'b0, 1'b0, 1'b0, D_NONE, FL_RETURN);
    case (addr)
      // idle: wait for a coefficient refresh or an input request
      STEP_W'(0):  w = uw(A_CUT, B_QN,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_DISPATCH);
      // coefficients
      STEP_W'(1):  w = uw(A_CUT, B_QN,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(2):  w = uw(A_QN,  B_K56, BS_ZERO, XS_PROD,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_T0, FL_NEXT);
      STEP_W'(3):  w = uw(A_T0,  B_K08, BS_ZERO, XS_PROD,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(4):  w = uw(A_T1,  B_QN,  BS_CUT,  XS_PROD,  SH_32,   1'b0, 1'b0, 1'b0,
                          D_PC, FL_NEXT);
      STEP_W'(5):  w = uw(A_CUT, B_QN,  BS_CUT,  XS_PROD,  SH_32,   1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(6):  w = uw(A_T1,  B_QN,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(7):  w = uw(A_CUT, B_QN,  BS_ONE,  XS_PROD,  SH_17,   1'b0, 1'b0, 1'b0,
                          D_T0, FL_NEXT);
      STEP_W'(8):  w = uw(A_T0,  B_RES, BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(9):  w = uw(A_CUT, B_QN,  BS_ZERO, XS_PROD,  SH_16,   1'b0, 1'b0, 1'b0,
                          D_KQ, FL_RETURN);
      // filter: feedback and input stage
      STEP_W'(10): w = uw(A_KQ,  B_ST4, BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(11): w = uw(A_CUT, B_QN,  BS_XIN,  XS_PROD,  SH_16,   1'b1, 1'b0, 1'b1,
                          D_T0, FL_NEXT);
      STEP_W'(12): w = uw(A_CUT, B_QN,  BS_T0,   XS_PRIOR, SH_0,    1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(13): w = uw(A_T1,  B_PC,  BS_ZERO, XS_T0,    SH_0,    1'b0, 1'b0, 1'b0,
                          D_PRIOR, FL_NEXT);
      // pole 1
      STEP_W'(14): w = uw(A_ST1, B_FB,  BS_ZERO, XS_PROD,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_ACC, FL_NEXT);
      STEP_W'(15): w = uw(A_CUT, B_QN,  BS_ACC,  XS_PROD,  SH_0,    1'b1, 1'b1, 1'b1,
                          D_T0, FL_NEXT);
      STEP_W'(16): w = uw(A_CUT, B_QN,  BS_T0,   XS_ST1,   SH_0,    1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(17): w = uw(A_T1,  B_PC,  BS_ZERO, XS_T0,    SH_0,    1'b0, 1'b0, 1'b0,
                          D_ST1, FL_NEXT);
      // pole 2
      STEP_W'(18): w = uw(A_ST2, B_FB,  BS_ZERO, XS_PROD,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_ACC, FL_NEXT);
      STEP_W'(19): w = uw(A_CUT, B_QN,  BS_ACC,  XS_PROD,  SH_0,    1'b1, 1'b1, 1'b1,
                          D_T0, FL_NEXT);
      STEP_W'(20): w = uw(A_CUT, B_QN,  BS_T0,   XS_ST2,   SH_0,    1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(21): w = uw(A_T1,  B_PC,  BS_ZERO, XS_T0,    SH_0,    1'b0, 1'b0, 1'b0,
                          D_ST2, FL_NEXT);
      // pole 3
      STEP_W'(22): w = uw(A_ST3, B_FB,  BS_ZERO, XS_PROD,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_ACC, FL_NEXT);
      STEP_W'(23): w = uw(A_CUT, B_QN,  BS_ACC,  XS_PROD,  SH_0,    1'b1, 1'b1, 1'b1,
                          D_T0, FL_NEXT);
      STEP_W'(24): w = uw(A_CUT, B_QN,  BS_T0,   XS_ST3,   SH_0,    1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(25): w = uw(A_T1,  B_PC,  BS_ZERO, XS_T0,    SH_0,    1'b0, 1'b0, 1'b0,
                          D_ST3, FL_NEXT);
      // pole 4, result v kept in T0
      STEP_W'(26): w = uw(A_ST4, B_FB,  BS_ZERO, XS_PROD,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_ACC, FL_NEXT);
      STEP_W'(27): w = uw(A_CUT, B_QN,  BS_ACC,  XS_PROD,  SH_0,    1'b1, 1'b1, 1'b1,
                          D_T0, FL_NEXT);
      // soft clip v - v^3/6
      STEP_W'(28): w = uw(A_T0,  B_T0,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(29): w = uw(A_CUT, B_QN,  BS_ZERO, XS_PROD,  SH_FRAC, 1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(30): w = uw(A_T1,  B_K6,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(31): w = uw(A_CUT, B_QN,  BS_ZERO, XS_PROD,  SH_16,   1'b0, 1'b0, 1'b0,
                          D_T1, FL_NEXT);
      STEP_W'(32): w = uw(A_T1,  B_T0,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_NEXT);
      STEP_W'(33): w = uw(A_CUT, B_QN,  BS_T0,   XS_PROD,  SH_FRAC, 1'b1, 1'b0, 1'b1,
                          D_ST4, FL_EMIT);
      default:     w = uw(A_CUT, B_QN,  BS_ZERO, XS_ZERO,  SH_0,    1'b0, 1'b0, 1'b0,
                          D_NONE, FL_RETURN);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/ladder_lowpass_filter_with_peak_core.sv
// Four-pole resonant ladder lowpass with soft clip and peak meter, microcoded datapath.
//
//  channel | signals                                   | dir | accepted when
//  --------+-------------------------------------------+-----+----------------------------
//  in      | in_valid_i, in_ready_o, in_data_i         | in  | in_valid_i & in_ready_o
//  out     | out_valid_o, out_ready_i, out_data_o      | out | out_valid_o & out_ready_i
//  apb     | psel, penable, pwrite, paddr, pwdata,     | in  | psel & penable & pwrite
//          | prdata, pready (tied high)                |     |
//
//  An input request passes the dispatch step, then 24 sequencer steps that share
//  one registered multiplier and one add/shift/saturate unit; the multiplier chain of the
//  four poles and the cubic clip fills those steps. One item is in flight at a time.
//  After reset and after every register write a 9-step run derives pc, fb and kq from the
//  registers; in_ready_o stays low until it finishes.
//  The last step waits while a finished result sits unclaimed in the output register.
module ladder_lowpass_filter_with_peak_core
  import llf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration and coefficient refresh
  logic [CFG_W-1:0]  cutoff_q, resonance_q;
  logic              dirty_q, dirty_d;
  logic              cfg_wr;

  // sequencer
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              advance, in_fire, coef_go, emit_fire;

  // datapath registers
  sample_t           xin_q;
  logic              sor_q;
  prod_t             prod_q, prod_d;
  acc_t              acc_q;
  tmp_t              t0_q, t1_q;
  coef_t             pc_q, kq_q, fb;
  state_t            prior_q, st1_q, st2_q, st3_q, st4_q;
  peak_t             lo_pk_q, hi_pk_q;
  out_item_t         out_q;
  logic              out_valid_q, out_valid_d;

  logic [QN_W-1:0]   qn;
  mul_a_t            mul_a;
  mul_b_t            mul_b;
  raw_t              base_v, x_v, x_s, raw, res, res_out;
  logic [RAW_W-STATE_W:0] res_hi;
  logic              res_in_rng;

  // output path
  state_t            st4_new, y_sh;
  logic [STATE_W-SAMPLE_W:0] y_hi;
  sample_t           y;
  peak_t             y_ext, lo_base, hi_base, lo_new, hi_new, neg_lo, peak;

  // -------------------------------------------------------------------------
  // APB register file: index is the word address, low byte bits ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[APB_AW-1])
      REG_CUTOFF:    prdata = APB_DW'(cutoff_q);
      REG_RESONANCE: prdata = APB_DW'(resonance_q);
      default:       prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Derived coefficients: qn = 1 - c (Q0.16, can reach 1.0), fb = 2*pc - 1.
  assign qn = QN_W'(ONE_Q16) - QN_W'(cutoff_q);
  assign fb = (pc_q <<< 1) - coef_t'(ONE_Q16);

  // -------------------------------------------------------------------------
  // Sequencer: one control word per step from the ROM.
  assign uc = ucode_rom(step_q);

  assign advance    = !((uc.flow == FL_EMIT) && out_valid_q && !out_ready_i);
  assign in_ready_o = (uc.flow == FL_DISPATCH) && !dirty_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign coef_go    = (uc.flow == FL_DISPATCH) && dirty_q;
  assign emit_fire  = (uc.flow == FL_EMIT) && advance;

  always_comb begin
    case (uc.flow)
      FL_NEXT:     step_d = step_q + 1'b1;
      FL_DISPATCH: begin
        if (coef_go) begin
          step_d = ADDR_COEF;
        end else if (in_fire) begin
          step_d = ADDR_FILT;
        end else begin
          step_d = step_q;
        end
      end
      FL_RETURN:   step_d = ADDR_IDLE;
      FL_EMIT:     step_d = advance ? ADDR_IDLE : step_q;
      default:     step_d = ADDR_IDLE;
    endcase
  end

  // a write during a refresh run leaves the flag set, so the run repeats
  assign dirty_d     = cfg_wr | (dirty_q & ~coef_go);
  assign out_valid_d = emit_fire | (out_valid_q & ~out_ready_i);

  // -------------------------------------------------------------------------
  // Multiplier: operands chosen by the control word, product registered.
  always_comb begin
    case (uc.a_sel)
      A_CUT:   mul_a = mul_a_t'(cutoff_q);
      A_QN:    mul_a = mul_a_t'(qn);
      A_T0:    mul_a = t0_q;
      A_T1:    mul_a = t1_q;
      A_KQ:    mul_a = mul_a_t'(kq_q);
      A_ST1:   mul_a = mul_a_t'(st1_q);
      A_ST2:   mul_a = mul_a_t'(st2_q);
      A_ST3:   mul_a = mul_a_t'(st3_q);
      A_ST4:   mul_a = mul_a_t'(st4_q);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (uc.b_sel)
      B_QN:    mul_b = mul_b_t'(qn);
      B_K56:   mul_b = mul_b_t'(K_FIVE_SIX);
      B_K08:   mul_b = mul_b_t'(K_EIGHT_TENTHS);
      B_K6:    mul_b = mul_b_t'(K_SIXTH);
      B_PC:    mul_b = mul_b_t'(pc_q);
      B_FB:    mul_b = mul_b_t'(fb);
      B_RES:   mul_b = mul_b_t'(resonance_q);
      B_ST4:   mul_b = mul_b_t'(st4_q);
      B_T0:    mul_b = mul_b_t'(t0_q);
      default: mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // -------------------------------------------------------------------------
  // ALU: res = (base +/- (x >>> xsh)) >>> rsh, optionally clamped to the state range.
  always_comb begin
    case (uc.base)
      BS_ZERO: base_v = '0;
      BS_ACC:  base_v = raw_t'(acc_q);
      BS_CUT:  base_v = raw_t'(cutoff_q);
      BS_ONE:  base_v = raw_t'(ONE_Q16);
      BS_XIN:  base_v = raw_t'(xin_q) <<< ALIGN_SH;
      BS_T0:   base_v = raw_t'(t0_q);
      default: base_v = '0;
    endcase
  end

  always_comb begin
    case (uc.xsrc)
      XS_ZERO:  x_v = '0;
      XS_PROD:  x_v = raw_t'(prod_q);
      XS_PRIOR: x_v = raw_t'(prior_q);
      XS_T0:    x_v = raw_t'(t0_q);
      XS_ST1:   x_v = raw_t'(st1_q);
      XS_ST2:   x_v = raw_t'(st2_q);
      XS_ST3:   x_v = raw_t'(st3_q);
      default:  x_v = '0;
    endcase
  end

  // arithmetic shifts floor toward minus infinity
  always_comb begin
    case (uc.xsh)
      SH_0:    x_s = x_v;
      SH_16:   x_s = x_v >>> 16;
      SH_17:   x_s = x_v >>> 17;
      SH_FRAC: x_s = x_v >>> FRAC_ST;
      SH_32:   x_s = x_v >>> 32;
      default: x_s = x_v;
    endcase
  end

  assign raw        = uc.neg ? (base_v - x_s) : (base_v + x_s);
  assign res        = uc.rsh ? (raw >>> 16) : raw;
  assign res_hi     = res[RAW_W-1:STATE_W-1];
  assign res_in_rng = (&res_hi) | (~|res_hi);

  always_comb begin
    res_out = res;
    if (uc.sat && !res_in_rng) begin
      res_out = res[RAW_W-1] ? raw_t'(state_t'({1'b1, {(STATE_W-1){1'b0}}}))
                             : raw_t'(state_t'({1'b0, {(STATE_W-1){1'b1}}}));
    end
  end

  // -------------------------------------------------------------------------
  // Output sample and peak trackers, evaluated in the emitting step.
  assign st4_new = res_out[STATE_W-1:0];
  assign y_sh    = st4_new >>> ALIGN_SH;
  assign y_hi    = y_sh[STATE_W-1:SAMPLE_W-1];

  always_comb begin
    if ((&y_hi) | (~|y_hi)) begin
      y = y_sh[SAMPLE_W-1:0];
    end else begin
      y = y_sh[STATE_W-1] ? sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}})
                          : sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
    end
  end

  assign y_ext   = peak_t'(y);
  assign lo_base = sor_q ? '0 : lo_pk_q;
  assign hi_base = sor_q ? '0 : hi_pk_q;
  // zero never moves a tracker: lo stays <= 0 and hi stays >= 0
  assign lo_new  = (y_ext < lo_base) ? y_ext : lo_base;
  assign hi_new  = (y_ext > hi_base) ? y_ext : hi_base;
  assign neg_lo  = -lo_new;
  assign peak    = (neg_lo > hi_new) ? neg_lo : hi_new;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // -------------------------------------------------------------------------
  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ADDR_IDLE;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      cutoff_q    <= CUTOFF_RST;
      resonance_q <= RESO_RST;
      prior_q     <= '0;
      st1_q       <= '0;
      st2_q       <= '0;
      st3_q       <= '0;
      st4_q       <= '0;
      lo_pk_q     <= '0;
      hi_pk_q     <= '0;
    end else begin
      step_q      <= step_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        case (paddr[APB_AW-1])
          REG_CUTOFF:    cutoff_q    <= pwdata[CFG_W-1:0];
          REG_RESONANCE: resonance_q <= pwdata[CFG_W-1:0];
          default:       cutoff_q    <= cutoff_q;
        endcase
      end
      if (advance) begin
        case (uc.dest)
          D_PRIOR: prior_q <= res_out[STATE_W-1:0];
          D_ST1:   st1_q   <= res_out[STATE_W-1:0];
          D_ST2:   st2_q   <= res_out[STATE_W-1:0];
          D_ST3:   st3_q   <= res_out[STATE_W-1:0];
          D_ST4:   st4_q   <= res_out[STATE_W-1:0];
          default: prior_q <= prior_q;
        endcase
      end
      if (emit_fire) begin
        lo_pk_q <= lo_new;
        hi_pk_q <= hi_new;
      end
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      xin_q <= in_data_i.sample_in;
      sor_q <= in_data_i.start_of_run;
    end
    if (advance) begin
      prod_q <= prod_d;
      case (uc.dest)
        D_ACC:   acc_q <= raw[ACC_W-1:0];
        D_T0:    t0_q  <= res_out[TMP_W-1:0];
        D_T1:    t1_q  <= res_out[TMP_W-1:0];
        D_PC:    pc_q  <= res_out[COEF_W-1:0];
        D_KQ:    kq_q  <= res_out[COEF_W-1:0];
        default: acc_q <= acc_q;
      endcase
    end
    if (emit_fire) begin
      out_q.sample_out <= y;
      out_q.peak_level <= peak[SAMPLE_W-1:0];
    end
  end

endmodule

>>> tb/sv/tb_ladder_lowpass_filter_with_peak_core.sv
// Self-checking testbench for the ladder lowpass core: directed rows, then APB setting sweeps.
module tb_ladder_lowpass_filter_with_peak_core
  import llf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. Eight register settings with 200 random requests each, on top of the opening rows.
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int IDLE_PCT      = 15;
  // Worst gap between two handshakes is a coefficient refresh plus one request plus
  // a random receiver stall; the quiet-cycle limit is far beyond any correct run.
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_REPORTS   = 40;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

  // One line of the opening stimulus: either a register write or a request.
  // A pinned request carries its result typed in; the rest go through the predictor.
  typedef struct {
    row_kind_e        kind;
    logic             idx;
    logic [APB_DW-1:0] value;
    logic             mark;
    logic             pinned;
    out_item_t        want;
  } row_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ladder_lowpass_filter_with_peak_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor copy of the registers and the filter state (state units: Q4.20 in a longint).
  logic [CFG_W-1:0] cutoff_cfg;
  logic [CFG_W-1:0] reso_cfg;
  longint           feed_prev, pole1, pole2, pole3, pole4;
  longint           trough, crest;   // most negative / most positive output since the mark

  out_item_t pending_filtered[$];    // results owed by the core, oldest first
  out_item_t oldest;
  row_t      opening_rows[$];

  // Set during one whole phase: neither side idles.
  logic steady = 1'b0;

  int n_errors   = 0;
  int n_requests = 0;
  int n_results  = 0;
  int n_writes   = 0;
  int n_marks    = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    if (n_errors < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    n_errors++;
  endtask

  // queue helpers: append at the tail
  task automatic add_row(input row_t row);
    opening_rows.insert(opening_rows.size(), row);
  endtask

  task automatic book_result(input out_item_t item);
    pending_filtered.insert(pending_filtered.size(), item);
  endtask

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // One ladder pole; every product floors, the stored value saturates.
  function automatic longint pole(input longint a, input longint b, input longint prev,
                                  input longint pc, input longint fb);
    return clamp_to(((a + b) * pc - prev * fb) >>> 16, STATE_W);
  endfunction

  // Full filter step for one request: coefficients from the current registers, feedback,
  // four poles, cubic soft clip, output saturation and the peak meter.
  function automatic out_item_t ladder_step(input in_item_t req);
    longint    c, r, qn, pc, fb, inner, gain, kq;
    longint    x, fin, s1, s2, s3, v, sq, sixth, cube, clipped, y, mag;
    out_item_t res;
    c     = longint'({1'b0, cutoff_cfg});
    r     = longint'({1'b0, reso_cfg});
    qn    = ONE_Q16 - c;
    pc    = c + ((c * qn * K_EIGHT_TENTHS) >>> 32);
    fb    = 2 * pc - ONE_Q16;
    inner = ONE_Q16 - qn + ((qn * qn * K_FIVE_SIX) >>> 32);
    gain  = ONE_Q16 + ((inner * qn) >>> 17);
    kq    = (r * gain) >>> 16;

    x   = longint'($signed(req.sample_in)) * (longint'(1) <<< ALIGN_SH);
    fin = clamp_to(x - ((kq * pole4) >>> 16), STATE_W);
    s1  = pole(fin, feed_prev, pole1, pc, fb);
    s2  = pole(s1, pole1, pole2, pc, fb);
    s3  = pole(s2, pole2, pole3, pc, fb);
    v   = pole(s3, pole3, pole4, pc, fb);

    sq      = (v * v) >>> FRAC_ST;
    sixth   = (sq * K_SIXTH) >>> 16;
    cube    = (sixth * v) >>> FRAC_ST;
    clipped = clamp_to(v - cube, STATE_W);

    pole1     = s1;
    pole2     = s2;
    pole3     = s3;
    pole4     = clipped;
    feed_prev = fin;

    y = clamp_to(clipped >>> ALIGN_SH, SAMPLE_W);
    if (req.start_of_run) begin
      trough = 0;
      crest  = 0;
    end
    // zero output leaves both trackers alone
    if (y < trough) trough = y;
    if (y > crest) crest = y;
    mag = (-trough > crest) ? -trough : crest;

    res.sample_out = sample_t'(y);
    res.peak_level = mag[SAMPLE_W-1:0];
    return res;
  endfunction

  function automatic row_t sample_row(input int s, input logic mark, input logic pinned);
    row_t row;
    row.kind   = ROW_SAMPLE;
    row.idx    = REG_CUTOFF;
    row.value  = APB_DW'(s);
    row.mark   = mark;
    row.pinned = pinned;
    row.want   = '0;
    return row;
  endfunction

  function automatic row_t reg_row(input logic idx, input logic [APB_DW-1:0] value);
    row_t row;
    row.kind   = ROW_REG;
    row.idx    = idx;
    row.value  = value;
    row.mark   = 1'b0;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  // Present one request, hold it until taken, then book its result.
  task automatic send_request(input in_item_t req, input logic pinned, input out_item_t want);
    out_item_t guess;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    guess = ladder_step(req);
    book_result(pinned ? want : guess);
    n_requests++;
    if (req.start_of_run) n_marks++;
  endtask

  // Stop sending and wait for every owed result; the core is idle after that.
  task automatic drain_filter();
    in_valid_i <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write, then read back. Each transfer ends with the bus returned to idle.
  task automatic program_reg(input logic idx, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_CUTOFF) cutoff_cfg = data[CFG_W-1:0];
    else reso_cfg = data[CFG_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (seen !== {{(APB_DW-CFG_W){1'b0}}, data[CFG_W-1:0]}) begin
      flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, seen, data));
    end
    n_writes++;
  endtask

  // Receiver: random back-pressure, and every accepted result checked against the oldest owed.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_filtered.size() == 0) begin
        flag_mismatch($sformatf("unrequested result %h", out_data_o));
      end else begin
        oldest = pending_filtered.pop_front();
        if (out_data_o.sample_out !== oldest.sample_out) begin
          flag_mismatch($sformatf("sample_out %0d, predicted %0d (result %0d)",
                                  out_data_o.sample_out, oldest.sample_out, n_results));
        end
        if (out_data_o.peak_level !== oldest.peak_level) begin
          flag_mismatch($sformatf("peak_level %0d, predicted %0d (result %0d)",
                                  out_data_o.peak_level, oldest.peak_level, n_results));
        end
        n_results++;
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: %0d quiet cycles, %0d results still owed",
               quiet_cycles, pending_filtered.size());
      $display("[ladder_lowpass_filter_with_peak_core] ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t         req;
    logic [CFG_W-1:0] plan_cut [RANDOM_PHASES];
    logic [CFG_W-1:0] plan_res [RANDOM_PHASES];
    int               shape;
    sample_t          level;
    logic [15:0]      sweep;
    logic [15:0]      stride;
    sample_t          s;

    cutoff_cfg = CUTOFF_RST;
    reso_cfg   = RESO_RST;
    feed_prev  = 0;
    pole1      = 0;
    pole2      = 0;
    pole3      = 0;
    pole4      = 0;
    trough     = 0;
    crest      = 0;
    sweep      = '0;
    stride     = 16'd1;
    level      = '0;
    shape      = 0;

    // Opening rows. Right after reset with a zero input nothing moves. With cutoff at zero the
    // pole gain vanishes and feedback sees a zero last stage, so even full-scale inputs and
    // full resonance leave the output and the meter at zero: those rows are typed in.
    add_row(sample_row(0, 1'b1, 1'b1));
    add_row(sample_row(0, 1'b0, 1'b1));
    add_row(reg_row(REG_CUTOFF, 32'hFFFF_0000));        // junk above bit 15
    add_row(sample_row(32767, 1'b0, 1'b1));
    add_row(sample_row(-32768, 1'b1, 1'b1));
    add_row(reg_row(REG_RESONANCE, 32'h0000_FFFF));
    add_row(sample_row(32767, 1'b0, 1'b1));
    add_row(sample_row(-1, 1'b1, 1'b1));
    // Back to the reset cutoff: step responses at both rails, then a fresh run mark.
    add_row(reg_row(REG_CUTOFF, {16'h5A5A, CUTOFF_RST}));
    add_row(reg_row(REG_RESONANCE, 32'hA5A5_0000));
    for (int i = 0; i < 4; i++) add_row(sample_row(32767, 1'b0, 1'b0));
    for (int i = 0; i < 4; i++) add_row(sample_row(-32768, 1'b0, 1'b0));
    add_row(sample_row(0, 1'b1, 1'b0));
    // Widest cutoff, then full resonance on top: drives poles and the clip into saturation.
    add_row(reg_row(REG_CUTOFF, 32'h0000_FFFF));
    add_row(sample_row(32767, 1'b0, 1'b0));
    add_row(sample_row(32767, 1'b0, 1'b0));
    add_row(sample_row(-32768, 1'b0, 1'b0));
    add_row(sample_row(-32768, 1'b0, 1'b0));
    add_row(reg_row(REG_RESONANCE, 32'h1234_FFFF));
    for (int i = 0; i < 3; i++) add_row(sample_row(32767, 1'b0, 1'b0));
    add_row(sample_row(-32768, 1'b1, 1'b0));
    add_row(sample_row(1, 1'b0, 1'b0));
    add_row(sample_row(-1, 1'b0, 1'b0));

    // Settings of the random phases: rails, the reset cutoff, tiny and mid values, two random.
    plan_cut = '{16'hFFFF, 16'h0000, 16'hFFFF, CUTOFF_RST, 16'h0001, 16'h8000, 16'h0, 16'h0};
    plan_res = '{16'h0000, 16'hFFFF, 16'hFFFF, RESO_RST,   16'h0001, 16'hC000, 16'h0, 16'h0};
    for (int ph = 6; ph < RANDOM_PHASES; ph++) begin
      plan_cut[ph] = CFG_W'($urandom);
      plan_res[ph] = CFG_W'($urandom);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_REG) begin
        drain_filter();
        program_reg(opening_rows[i].idx, opening_rows[i].value);
      end else begin
        req.sample_in    = opening_rows[i].value[SAMPLE_W-1:0];
        req.start_of_run = opening_rows[i].mark;
        send_request(req, opening_rows[i].pinned, opening_rows[i].want);
      end
    end

    // Random phases. Input shape changes every 32 requests: full-range noise, quiet noise,
    // a full-scale square wave, a sawtooth, or a held level (step response).
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_filter();
      steady = (ph == 3);
      program_reg(REG_CUTOFF, {16'($urandom), plan_cut[ph]});
      program_reg(REG_RESONANCE, {16'($urandom), plan_res[ph]});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          shape  = $urandom_range(4);
          level  = sample_t'($urandom);
          stride = 16'($urandom_range(1, 4096));
        end
        case (shape)
          0: s = sample_t'($urandom);
          1: s = sample_t'(int'($urandom_range(0, 1023)) - 512);
          2: s = sample_t'(((n / 8) % 2 == 1) ? 32767 : -32768);
          3: begin
            sweep = sweep + stride;
            s     = sample_t'(sweep);
          end
          default: s = level;
        endcase
        req.sample_in    = s;
        req.start_of_run = ($urandom_range(99) < 4);
        send_request(req, 1'b0, '0);
        // sender holds off mid-phase until the core has handed back everything
        if (ph == 5 && n == PHASE_ITEMS / 2) drain_filter();
      end
    end

    drain_filter();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered: %0d filter requests (%0d with a run mark), %0d results compared",
             n_requests, n_marks, n_results);
    $display("covered: %0d register writes with readback over %0d settings phases",
             n_writes, RANDOM_PHASES);
    if (n_errors == 0) begin
      $display("[ladder_lowpass_filter_with_peak_core] OK");
    end else begin
      $display("[ladder_lowpass_filter_with_peak_core] ERROR");
    end
    $finish;
  end

endmodule
